@@ rtl/pesb_pkg.sv @@
// Shared types, codes and constants for the polygon edge span builder.
package pesb_pkg;

    localparam int ROWS_DEF   = 128;
    localparam int ROW_W      = 7;
    localparam int X_W        = 16;
    localparam int ACC_W      = 40;
    localparam int QUO_W      = 32;
    localparam int Q_DEPTH    = 2;
    localparam int IN_DATA_W  = 72;
    localparam int OUT_DATA_W = 136;

    localparam logic [1:0] KIND_CLEAR  = 2'd0;
    localparam logic [1:0] KIND_EDGE   = 2'd1;
    localparam logic [1:0] KIND_READ   = 2'd2;
    localparam logic [1:0] KIND_UNUSED = 2'd3;

    localparam logic REPORT_EDGE = 1'b0;
    localparam logic REPORT_ROW  = 1'b1;

    localparam logic CFG_TOP    = 1'b0;
    localparam logic CFG_BOTTOM = 1'b1;

    localparam logic [ROW_W-1:0] WIN_TOP_RST = 7'd0;
    localparam logic [ROW_W-1:0] WIN_BOT_RST = 7'd127;

    localparam logic signed [X_W-1:0] X_MAX = 16'sh7fff;
    localparam logic signed [X_W-1:0] X_MIN = 16'sh8000;

    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_CLEAR,
        ST_READ,
        ST_READ_OUT,
        ST_DIV,
        ST_SLOPE,
        ST_CLIP_MUL,
        ST_CLIP_ADD,
        ST_ROWS,
        ST_FLUSH,
        ST_DONE
    } pesb_state_t;

    typedef struct packed {
        logic [1:0]              kind;
        logic signed [X_W-1:0]   ax;
        logic signed [X_W-1:0]   ay;
        logic signed [X_W-1:0]   bx;
        logic signed [X_W-1:0]   by;
        logic                    upward;
        logic                    horizontal;
        logic                    invisible;
        logic                    clip_top;
        logic [ROW_W-1:0]        first_row;
        logic [ROW_W-1:0]        last_row;
        logic [ROW_W-1:0]        row_select;
        logic [X_W-1:0]          clip_rows;
    } pesb_cmd_t;

    typedef struct packed {
        logic init_busy;
    } pesb_status_t;

endpackage

@@ rtl/pesb_front.sv @@
// Input side: window registers, edge ordering and classification.
module pesb_front
    import pesb_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic                 cfg_index,
    input  logic [ROW_W-1:0]     cfg_data,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [IN_DATA_W-1:0] s_tdata,
    input  logic [1:0]           s_tuser,
    input  logic                 q_full,
    input  pesb_status_t         status,
    output logic                 push,
    output pesb_cmd_t            cmd
);

    logic [ROW_W-1:0]      win_top_reg;
    logic [ROW_W-1:0]      win_bot_reg;
    logic signed [X_W-1:0] ax0, ay0, bx0, by0;
    logic signed [X_W-1:0] wt_s, wb_s;
    logic                  swap;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_top_reg <= WIN_TOP_RST;
            win_bot_reg <= WIN_BOT_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_TOP:    win_top_reg <= cfg_data;
                CFG_BOTTOM: win_bot_reg <= cfg_data;
                default:    win_top_reg <= win_top_reg;
            endcase
        end
    end

    assign s_tready = !q_full && !status.init_busy;
    assign push     = s_tvalid && s_tready;

    always_comb
    begin
        ax0  = $signed(s_tdata[15:0]);
        ay0  = $signed(s_tdata[31:16]);
        bx0  = $signed(s_tdata[47:32]);
        by0  = $signed(s_tdata[63:48]);
        wt_s = $signed({9'd0, win_top_reg});
        wb_s = $signed({9'd0, win_bot_reg});
        swap = ay0 > by0;

        cmd.kind       = s_tuser;
        cmd.ax         = swap ? bx0 : ax0;
        cmd.ay         = swap ? by0 : ay0;
        cmd.bx         = swap ? ax0 : bx0;
        cmd.by         = swap ? ay0 : by0;
        cmd.upward     = swap;
        cmd.horizontal = (cmd.ay == cmd.by);
        cmd.invisible  = (win_bot_reg < win_top_reg) || !(cmd.ay <= wb_s && wt_s <= cmd.by);
        cmd.clip_top   = cmd.ay < wt_s;
        cmd.first_row  = cmd.clip_top ? win_top_reg : cmd.ay[ROW_W-1:0];
        cmd.last_row   = (cmd.by > wb_s) ? win_bot_reg : cmd.by[ROW_W-1:0];
        cmd.row_select = s_tdata[70:64];
        cmd.clip_rows  = X_W'(wt_s - cmd.ay);
    end

endmodule

@@ rtl/pesb_queue.sv @@
// Short command queue between the input side and the span engine.
module pesb_queue
    import pesb_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  pesb_cmd_t din,
    output logic      full,
    input  logic      pop,
    output logic      valid,
    output pesb_cmd_t dout
);

    localparam int PW = $clog2(Q_DEPTH);
    localparam int CW = $clog2(Q_DEPTH + 1);

    pesb_cmd_t     entry_reg [Q_DEPTH];
    logic [PW-1:0] wp_reg, rp_reg;
    logic [CW-1:0] cnt_reg;

    assign full  = (cnt_reg == CW'(Q_DEPTH));
    assign valid = (cnt_reg != '0);
    assign dout  = entry_reg[rp_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wp_reg] <= din;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wp_reg <= wp_reg + 1'b1;
            end
            if (pop)
            begin
                rp_reg <= rp_reg + 1'b1;
            end
            if (push && !pop)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

endmodule

@@ rtl/pesb_back.sv @@
// Span engine: slope divider, top clip, row stepper, span store and result register.
module pesb_back
    import pesb_pkg::*;
#(
    parameter int ROWS = ROWS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  q_valid,
    input  pesb_cmd_t             q_cmd,
    output logic                  pop,
    output pesb_status_t          status,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,
    output logic [0:0]            m_tuser
);

    localparam int IW = $clog2(ROWS);

    function automatic logic signed [X_W-1:0] sat16(input logic signed [25:0] v);
        logic signed [X_W-1:0] r;
        if (v > 26'sd32767)
        begin
            r = X_MAX;
        end
        else if (v < -26'sd32768)
        begin
            r = X_MIN;
        end
        else
        begin
            r = v[X_W-1:0];
        end
        return r;
    endfunction

    pesb_state_t state_reg, state_next;
    pesb_cmd_t   cmd_reg;

    logic [2*X_W-1:0]        store_mem [ROWS];
    logic [2*X_W-1:0]        rd_data_reg;
    logic                    we;
    logic [IW-1:0]           wa;
    logic [2*X_W-1:0]        wd;
    logic [ROW_W-1:0]        rd_row;

    logic [IW-1:0]           sweep_reg;
    logic                    sweep_last;
    logic [4:0]              div_cnt_reg;
    logic [QUO_W-1:0]        num_reg;
    logic [X_W-1:0]          rem_reg, dy_reg;
    logic                    neg_reg;
    logic signed [QUO_W-1:0] slope_reg;
    logic signed [32:0]      prod_reg;
    logic signed [X_W-1:0]   xa_reg, xb_reg;
    logic signed [ACC_W-1:0] acc_reg;
    logic [ROW_W-1:0]        y_reg;
    logic                    wr_valid_reg;
    logic [ROW_W-1:0]        wr_y_reg;
    logic signed [X_W-1:0]   wr_l_reg, wr_r_reg;
    logic signed [X_W-1:0]   region_lo_reg, region_hi_reg;
    logic                    m_tvalid_reg;
    logic [OUT_DATA_W-1:0]   out_data_reg;
    logic                    out_user_reg;

    logic signed [16:0]      dx17;
    logic [X_W-1:0]          adx;
    logic [16:0]             rem_sh;
    logic                    ge;
    logic signed [X_W-1:0]   s88;
    logic signed [25:0]      clip_sum;
    logic signed [X_W-1:0]   xa_clip;
    logic signed [X_W-1:0]   last_x;
    logic signed [X_W-1:0]   rd_l, rd_r;
    logic signed [X_W-1:0]   x_lo, x_hi;
    logic signed [X_W-1:0]   row_lo, row_hi;
    logic signed [X_W-1:0]   span_l, span_r;
    logic signed [X_W-1:0]   first_s, last_s;

    assign status.init_busy = (state_reg == ST_INIT);
    assign m_tvalid         = m_tvalid_reg;
    assign m_tdata          = out_data_reg;
    assign m_tuser          = out_user_reg;
    assign sweep_last       = (sweep_reg == IW'(ROWS - 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        pop        = 1'b0;
        case (state_reg)
            ST_INIT, ST_CLEAR:
            begin
                if (sweep_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (q_valid && !m_tvalid_reg)
                begin
                    pop = 1'b1;
                    case (q_cmd.kind)
                        KIND_CLEAR: state_next = ST_CLEAR;
                        KIND_READ:  state_next = ST_READ;
                        KIND_EDGE:
                        begin
                            if (q_cmd.invisible)
                            begin
                                state_next = ST_DONE;
                            end
                            else if (q_cmd.horizontal)
                            begin
                                state_next = ST_ROWS;
                            end
                            else
                            begin
                                state_next = ST_DIV;
                            end
                        end
                        default:    state_next = ST_IDLE;
                    endcase
                end
            end
            ST_READ:     state_next = ST_READ_OUT;
            ST_READ_OUT: state_next = ST_IDLE;
            ST_DIV:
            begin
                if (div_cnt_reg == '0)
                begin
                    state_next = ST_SLOPE;
                end
            end
            ST_SLOPE:    state_next = cmd_reg.clip_top ? ST_CLIP_MUL : ST_ROWS;
            ST_CLIP_MUL: state_next = ST_CLIP_ADD;
            ST_CLIP_ADD: state_next = ST_ROWS;
            ST_ROWS:
            begin
                if (y_reg == cmd_reg.last_row)
                begin
                    state_next = ST_FLUSH;
                end
            end
            ST_FLUSH:    state_next = ST_DONE;
            ST_DONE:     state_next = ST_IDLE;
            default:     state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        dx17     = $signed({q_cmd.bx[X_W-1], q_cmd.bx}) - $signed({q_cmd.ax[X_W-1], q_cmd.ax});
        adx      = dx17[16] ? X_W'(-dx17) : dx17[X_W-1:0];
        rem_sh   = {rem_reg, num_reg[QUO_W-1]};
        ge       = rem_sh >= {1'b0, dy_reg};
        s88      = sat16($signed({{2{slope_reg[31]}}, slope_reg[31:8]}));
        clip_sum = $signed({{10{xa_reg[X_W-1]}}, xa_reg})
                 + $signed({prod_reg[32], prod_reg[32:8]});
        xa_clip  = sat16(clip_sum);
        last_x   = sat16($signed({{2{acc_reg[ACC_W-1]}}, acc_reg[ACC_W-1:16]}));
        rd_l     = $signed(rd_data_reg[X_W-1:0]);
        rd_r     = $signed(rd_data_reg[2*X_W-1:X_W]);
        x_lo     = (xa_reg < xb_reg) ? xa_reg : xb_reg;
        x_hi     = (xa_reg < xb_reg) ? xb_reg : xa_reg;
        first_s  = $signed({9'd0, cmd_reg.first_row});
        last_s   = $signed({9'd0, cmd_reg.last_row});
        row_lo   = cmd_reg.invisible ? cmd_reg.ay : first_s;
        row_hi   = cmd_reg.invisible ? cmd_reg.by : last_s;
        span_l   = (32'(cmd_reg.row_select) < ROWS) ? rd_l : X_MAX;
        span_r   = (32'(cmd_reg.row_select) < ROWS) ? rd_r : X_MIN;
        rd_row   = (state_reg == ST_READ) ? cmd_reg.row_select : y_reg;
    end

    always_comb
    begin
        we = 1'b0;
        wa = '0;
        wd = '0;
        if (state_reg inside {ST_INIT, ST_CLEAR})
        begin
            we = 1'b1;
            wa = sweep_reg;
            wd = {X_MIN, X_MAX};
        end
        else if (wr_valid_reg && (32'(wr_y_reg) < ROWS))
        begin
            we = 1'b1;
            wa = IW'(wr_y_reg);
            wd = {((wr_r_reg > rd_r) ? wr_r_reg : rd_r), ((wr_l_reg < rd_l) ? wr_l_reg : rd_l)};
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            store_mem[wa] <= wd;
        end
        rd_data_reg <= store_mem[IW'(rd_row)];
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                cmd_reg <= q_cmd;
                xa_reg  <= q_cmd.ax;
                xb_reg  <= q_cmd.bx;
                y_reg   <= q_cmd.first_row;
                num_reg <= {adx, 16'h0000};
                rem_reg <= '0;
                dy_reg  <= X_W'(q_cmd.by - q_cmd.ay);
                neg_reg <= dx17[16];
            end
            ST_DIV:
            begin
                rem_reg <= ge ? X_W'(rem_sh - {1'b0, dy_reg}) : rem_sh[X_W-1:0];
                num_reg <= {num_reg[QUO_W-2:0], ge};
            end
            ST_SLOPE:
            begin
                if (neg_reg)
                begin
                    slope_reg <= num_reg[QUO_W-1] ? 32'sh80000000 : $signed(-num_reg);
                end
                else
                begin
                    slope_reg <= num_reg[QUO_W-1] ? 32'sh7fffffff : $signed(num_reg);
                end
                acc_reg <= $signed({{8{xa_reg[X_W-1]}}, xa_reg, 16'h0000});
            end
            ST_CLIP_MUL:
            begin
                prod_reg <= $signed({1'b0, cmd_reg.clip_rows}) * s88;
            end
            ST_CLIP_ADD:
            begin
                xa_reg  <= xa_clip;
                acc_reg <= $signed({{8{xa_clip[X_W-1]}}, xa_clip, 16'h0000});
            end
            ST_ROWS:
            begin
                wr_y_reg <= y_reg;
                wr_l_reg <= cmd_reg.horizontal ? x_lo : last_x;
                wr_r_reg <= cmd_reg.horizontal ? x_hi : last_x;
                acc_reg  <= acc_reg + $signed({{8{slope_reg[QUO_W-1]}}, slope_reg});
                y_reg    <= y_reg + 1'b1;
                if (!cmd_reg.horizontal)
                begin
                    xb_reg <= last_x;
                end
            end
            ST_DONE:
            begin
                out_user_reg <= REPORT_EDGE;
                out_data_reg <= {69'd0, x_hi, x_lo, row_hi, row_lo,
                                 cmd_reg.upward, cmd_reg.horizontal, cmd_reg.invisible};
            end
            ST_READ_OUT:
            begin
                out_user_reg <= REPORT_ROW;
                out_data_reg <= {5'd0, region_hi_reg, region_lo_reg, span_r, span_l, 67'd0};
            end
            default:
            begin
                acc_reg <= acc_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sweep_reg     <= '0;
            div_cnt_reg   <= '1;
            wr_valid_reg  <= 1'b0;
            region_lo_reg <= X_MAX;
            region_hi_reg <= X_MIN;
            m_tvalid_reg  <= 1'b0;
        end
        else
        begin
            wr_valid_reg <= (state_reg == ST_ROWS);
            if (state_reg inside {ST_INIT, ST_CLEAR})
            begin
                sweep_reg <= sweep_last ? '0 : sweep_reg + 1'b1;
            end
            if (state_reg == ST_DIV)
            begin
                div_cnt_reg <= div_cnt_reg - 1'b1;
            end
            else
            begin
                div_cnt_reg <= '1;
            end
            if (state_reg == ST_CLEAR)
            begin
                region_lo_reg <= X_MAX;
                region_hi_reg <= X_MIN;
            end
            else if (state_reg == ST_DONE && !cmd_reg.invisible)
            begin
                if (first_s < region_lo_reg)
                begin
                    region_lo_reg <= first_s;
                end
                if (last_s > region_hi_reg)
                begin
                    region_hi_reg <= last_s;
                end
            end
            if (state_reg inside {ST_DONE, ST_READ_OUT})
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

`ifndef NO_ASSERTIONS
    a_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) |-> (rem_reg < dy_reg))
        else $error("divider remainder not below divisor");

    a_row_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ROWS) |-> (y_reg <= cmd_reg.last_row))
        else $error("row stepper past last row");

    a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid_reg) |-> $past(state_reg == ST_DONE || state_reg == ST_READ_OUT))
        else $error("result raised outside a result state");

    a_pop_free: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> q_valid && !m_tvalid_reg)
        else $error("command taken while result pending");
`endif

endmodule

@@ rtl/polygon_edge_span_builder.sv @@
// Top level of the polygon edge span builder.
// Sloped edge: the slope divider runs, a top clip adds a multiply and an add step, then rows are stepped.
// Horizontal and invisible edges skip the divider; a row read gives a result, a clear gives none.
// One item in the engine at a time; the 32-step slope divider and one row per cycle set the rate.
// Two commands queue ahead of the engine and the result register holds one result.
// After reset the span store is swept over all ROWS rows with s_tready low; config is taken throughout.
module polygon_edge_span_builder
    import pesb_pkg::*;
#(
    parameter int ROWS = ROWS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic                  cfg_index,
    input  logic [ROW_W-1:0]      cfg_data,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // start_x, start_y, end_x, end_y, row_select, pad
    input  logic [IN_DATA_W-1:0]  s_tdata,
    // kind
    input  logic [1:0]            s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // edge_hidden, edge_flat, edge_upward, edge_row_low, edge_row_high,
    // edge_x_low, edge_x_high, row_left, row_right, region_row_low, region_row_high, pad
    output logic [OUT_DATA_W-1:0] m_tdata,
    // report_kind
    output logic [0:0]            m_tuser
);

    pesb_status_t status;
    pesb_cmd_t    push_cmd, q_cmd;
    logic         push, q_full, q_valid, pop;

    pesb_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .q_full    (q_full),
        .status    (status),
        .push      (push),
        .cmd       (push_cmd)
    );

    pesb_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .din   (push_cmd),
        .full  (q_full),
        .pop   (pop),
        .valid (q_valid),
        .dout  (q_cmd)
    );

    pesb_back #(
        .ROWS (ROWS)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (q_valid),
        .q_cmd    (q_cmd),
        .pop      (pop),
        .status   (status),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

@@ tb/tb_top.sv @@
// Testbench for polygon_edge_span_builder: directed table plus random items, predictor checked.
`timescale 1ns / 100ps

module tb_top
    import pesb_pkg::*;
();

    typedef struct {
        logic [1:0]  kind;
        shortint     sx, sy, ex, ey;
        logic [6:0]  row;
    } item_t;

    typedef struct {
        logic    rk, inv, hor, up;
        shortint rlo, rhi, xlo, xhi, left, right, reglo, reghi;
    } rep_t;

    typedef struct {
        item_t it;
        bit    has_exp;
        rep_t  exp;
    } row_t;

    logic clk = 0;
    logic rst_n = 0;
    logic cfg_we = 0;
    logic cfg_index = CFG_TOP;
    logic [ROW_W-1:0] cfg_data = '0;
    logic s_tvalid = 0;
    logic s_tready;
    logic [IN_DATA_W-1:0] s_tdata = '0;
    logic [1:0] s_tuser = '0;
    logic m_tvalid;
    logic m_tready = 0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic [0:0] m_tuser;

    polygon_edge_span_builder dut (.*);

    always #6 clk = ~clk;

    shortint span_left[128];
    shortint span_right[128];
    shortint touched_low, touched_high;
    int win_top, win_bottom;
    rep_t expected_reports[$];
    int errors = 0;
    int reports_seen = 0;
    int edges_sent = 0;
    int reads_sent = 0;
    bit calm = 0;

    function automatic longint floor_sh(longint v, int n);
        return v >>> n;
    endfunction

    function automatic longint sat(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic void check_field(string name, logic signed [31:0] exp_v,
                                        logic signed [31:0] act_v);
        if (act_v !== exp_v)
        begin
            $error("%s exp %0d got %0d", name, exp_v, act_v);
            errors++;
        end
    endfunction

    function automatic void span_clear();
        for (int i = 0; i < 128; i++)
        begin
            span_left[i] = 32767;
            span_right[i] = -32768;
        end
        touched_low = 32767;
        touched_high = -32768;
    endfunction

    function automatic void span_merge(longint r, longint xl, longint xr);
        if (r < 0 || r > 127)
            return;
        if (xl < span_left[r])
            span_left[r] = shortint'(xl);
        if (xr > span_right[r])
            span_right[r] = shortint'(xr);
    endfunction

    function automatic bit span_predict(item_t it, output rep_t r);
        longint ax, ay, bx, by, t, ylo, yhi, xa, xb, slope, s88, acc, lst;
        r = '{default: 0};
        if (it.kind == KIND_CLEAR)
        begin
            span_clear();
            return 0;
        end
        if (it.kind == KIND_READ)
        begin
            r.rk = REPORT_ROW;
            r.left = span_left[it.row];
            r.right = span_right[it.row];
            r.reglo = touched_low;
            r.reghi = touched_high;
            return 1;
        end
        if (it.kind != KIND_EDGE)
            return 0;
        ax = it.sx; ay = it.sy; bx = it.ex; by = it.ey;
        if (ay > by)
        begin
            t = ax; ax = bx; bx = t;
            t = ay; ay = by; by = t;
            r.up = 1;
        end
        ylo = ay; yhi = by;
        r.hor = (ylo == yhi);
        r.inv = (win_bottom < win_top) || !(ylo <= win_bottom && win_top <= yhi);
        xa = ax; xb = bx;
        if (!r.inv)
        begin
            if (r.hor)
                span_merge(ylo, xa < xb ? xa : xb, xa < xb ? xb : xa);
            else
            begin
                slope = sat(((bx - ax) * 65536) / (by - ay),
                            -64'sd2147483648, 64'sd2147483647);
                lst = 0;
                if (ay < win_top)
                begin
                    s88 = sat(floor_sh(slope, 8), -32768, 32767);
                    xa = sat(xa + floor_sh((win_top - ay) * s88, 8), -32768, 32767);
                    ylo = win_top;
                end
                if (yhi > win_bottom)
                    yhi = win_bottom;
                acc = xa * 65536;
                for (longint y = ylo; y <= yhi; y++)
                begin
                    lst = sat(floor_sh(acc, 16), -32768, 32767);
                    span_merge(y, lst, lst);
                    acc += slope;
                end
                xb = lst;
            end
            if (ylo < touched_low)
                touched_low = shortint'(ylo);
            if (yhi > touched_high)
                touched_high = shortint'(yhi);
        end
        r.rk = REPORT_EDGE;
        r.rlo = shortint'(ylo);
        r.rhi = shortint'(yhi);
        r.xlo = shortint'(xa < xb ? xa : xb);
        r.xhi = shortint'(xa < xb ? xb : xa);
        return 1;
    endfunction

    task automatic send_item(item_t it);
        rep_t r;
        if (span_predict(it, r))
            expected_reports.push_back(r);
        if (it.kind == KIND_EDGE)
            edges_sent++;
        if (it.kind == KIND_READ)
            reads_sent++;
        while (!calm && $urandom_range(99) < 9)
        begin
            s_tvalid <= 0;
            @(negedge clk);
        end
        s_tvalid <= 1;
        s_tuser <= it.kind;
        s_tdata <= {1'b0, it.row, it.ey, it.ex, it.sy, it.sx};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic drain_and_config(int top, int bottom);
        s_tvalid <= 0;
        while (expected_reports.size() != 0)
            @(negedge clk);
        repeat (500) @(negedge clk);
        cfg_we <= 1;
        cfg_index <= CFG_TOP;
        cfg_data <= top[6:0];
        @(negedge clk);
        cfg_index <= CFG_BOTTOM;
        cfg_data <= bottom[6:0];
        @(negedge clk);
        cfg_we <= 0;
        win_top = top;
        win_bottom = bottom;
    endtask

    function automatic item_t rand_item();
        item_t it;
        int p;
        p = $urandom_range(99);
        it.kind = p < 3 ? KIND_CLEAR :
                  (p < 60 ? KIND_EDGE : (p < 98 ? KIND_READ : KIND_UNUSED));
        it.row = 7'($urandom_range(127));
        if ($urandom_range(9) < 8)
        begin
            it.sx = shortint'($urandom_range(400) - 200);
            it.ex = shortint'($urandom_range(400) - 200);
            it.sy = shortint'($urandom_range(160) - 16);
            it.ey = ($urandom_range(5) == 0) ? it.sy : shortint'($urandom_range(160) - 16);
        end
        else
        begin
            it.sx = shortint'($urandom);
            it.sy = shortint'($urandom);
            it.ex = shortint'($urandom);
            it.ey = shortint'($urandom);
        end
        return it;
    endfunction

    always @(posedge clk)
    begin
        rep_t e, a;
        if (m_tvalid && m_tready)
        begin
            {a.reghi, a.reglo, a.right, a.left, a.xhi, a.xlo, a.rhi, a.rlo,
             a.up, a.hor, a.inv} = m_tdata[130:0];
            a.rk = m_tuser[0];
            reports_seen++;
            if (expected_reports.size() == 0)
            begin
                $error("unexpected report, report_kind %0d", a.rk);
                errors++;
            end
            else
            begin
                e = expected_reports.pop_front();
                check_field("report_kind", e.rk, a.rk);
                check_field("edge_hidden", e.inv, a.inv);
                check_field("edge_flat", e.hor, a.hor);
                check_field("edge_upward", e.up, a.up);
                check_field("edge_row_low", e.rlo, a.rlo);
                check_field("edge_row_high", e.rhi, a.rhi);
                check_field("edge_x_low", e.xlo, a.xlo);
                check_field("edge_x_high", e.xhi, a.xhi);
                check_field("row_left", e.left, a.left);
                check_field("row_right", e.right, a.right);
                check_field("region_row_low", e.reglo, a.reglo);
                check_field("region_row_high", e.reghi, a.reghi);
            end
        end
    end

    always @(negedge clk)
        m_tready <= calm ? 1'b1 : ($urandom_range(99) >= 9);

    initial
    begin
        #30ms;
        $display("FAIL");
        $finish;
    end

    initial
    begin
        row_t tbl[$];
        rep_t e;
        int settings[6][2] = '{'{0, 127}, '{0, 0}, '{127, 127}, '{20, 90}, '{90, 20}, '{5, 60}};
        span_clear();
        win_top = 0;
        win_bottom = 127;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1;

        // read of empty store after reset
        e = '{default: 0};
        e.rk = REPORT_ROW; e.left = 32767; e.right = -32768; e.reglo = 32767; e.reghi = -32768;
        tbl.push_back('{'{KIND_READ, 0, 0, 0, 0, 7'd127}, 1, e});
        // invisible: far above the window, swapped endpoints
        e = '{default: 0};
        e.inv = 1; e.up = 1; e.rlo = -32768; e.rhi = -5; e.xlo = 3; e.xhi = 9;
        tbl.push_back('{'{KIND_EDGE, 3, -5, 9, -32768, 0}, 1, e});
        // visible horizontal
        e = '{default: 0};
        e.hor = 1; e.rlo = 10; e.rhi = 10; e.xlo = -32768; e.xhi = 32767;
        tbl.push_back('{'{KIND_EDGE, 32767, 10, -32768, 10, 0}, 1, e});
        tbl.push_back('{'{KIND_EDGE, 0, -32768, 32767, 32767, 0}, 0, e});
        tbl.push_back('{'{KIND_EDGE, -32768, 200, 5, -40, 0}, 0, e});
        tbl.push_back('{'{KIND_EDGE, 10, 0, -10, 127, 0}, 0, e});
        tbl.push_back('{'{KIND_EDGE, 50, 126, 51, 127, 0}, 0, e});
        tbl.push_back('{'{KIND_READ, 0, 0, 0, 0, 7'd10}, 0, e});
        tbl.push_back('{'{KIND_READ, 0, 0, 0, 0, 7'd0}, 0, e});
        tbl.push_back('{'{KIND_UNUSED, -1, -1, -1, -1, 7'd127}, 0, e});
        tbl.push_back('{'{KIND_READ, 0, 0, 0, 0, 7'd64}, 0, e});
        tbl.push_back('{'{KIND_CLEAR, 0, 0, 0, 0, 0}, 0, e});
        e = '{default: 0};
        e.rk = REPORT_ROW; e.left = 32767; e.right = -32768; e.reglo = 32767; e.reghi = -32768;
        tbl.push_back('{'{KIND_READ, 0, 0, 0, 0, 7'd10}, 1, e});

        foreach (tbl[i])
        begin
            send_item(tbl[i].it);
            if (tbl[i].has_exp)
                expected_reports[$] = tbl[i].exp;
        end

        for (int s = 0; s < 6; s++)
        begin
            drain_and_config(settings[s][0], settings[s][1]);
            calm = (s == 2);
            for (int k = 0; k < 190; k++)
                send_item(rand_item());
        end
        calm = 0;
        s_tvalid <= 0;

        while (expected_reports.size() != 0)
            @(negedge clk);
        repeat (200) @(negedge clk);
        $display("Covered %0d edges and %0d row reads, %0d reports checked over 6 windows.",
                 edges_sent, reads_sent, reports_seen);
        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end
endmodule
